// File: src/elephant_flow_tracker_assert.svh
// Assertion macros for the elephant flow tracker.
// Expects signals clk and rst_n in the scope of use.
`ifndef ELEPHANT_FLOW_TRACKER_ASSERT_SVH
`define ELEPHANT_FLOW_TRACKER_ASSERT_SVH
`ifndef SYNTH
`define EFT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eft assertion failed");
`define EFT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eft assertion failed");
`else
`define EFT_ASSERT_IMP(label, ante, cons)
`define EFT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/eft_pkg.sv
// Shared types and constants for the elephant flow tracker.
// No dependencies.
package eft_pkg;

    localparam int FLOW_W   = 10;
    localparam int LEN_W    = 16;
    localparam int THR_W    = 24;
    localparam int CNT_W    = 25;
    localparam int DEM_W    = 11;
    localparam logic [DEM_W-1:0] DEMOTED_MAX = 11'd2047;

    localparam logic [1:0] MODE_PKT   = 2'd0;
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef enum logic [1:0] {
        OP_PKT   = 2'd0,
        OP_SWEEP = 2'd1,
        OP_QUERY = 2'd2,
        OP_NULL  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [FLOW_W-1:0] flow;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // head of the command queue, seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // back end control back to the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_status_t;

    // one table entry
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             el;
        logic             ag;
    } entry_t;

endpackage

// File: src/eft_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module eft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/eft_front.sv
// Front end: accepts items, classifies them into commands, two-entry queue.
// Depends on eft_pkg.
module eft_front #(
    parameter int NUM_FLOWS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [eft_pkg::FLOW_W-1:0]   flow_id,
    input  logic [eft_pkg::LEN_W-1:0]    byte_length,
    input  logic [eft_pkg::THR_W-1:0]    threshold,
    input  eft_pkg::back_status_t        status,
    output eft_pkg::q_head_t             head
);

    eft_pkg::cmd_t cmd_in;
    eft_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    logic          out_of_range;

    assign out_of_range = (32'(flow_id) >= 32'(NUM_FLOWS));

    always_comb
    begin
        cmd_in.flow = flow_id;
        cmd_in.len  = byte_length;
        unique case (mode)
            eft_pkg::MODE_SWEEP: cmd_in.op = eft_pkg::OP_SWEEP;
            eft_pkg::MODE_PKT:
            begin
                if (out_of_range)
                    cmd_in.op = eft_pkg::OP_NULL;
                else if (threshold != '0)
                    cmd_in.op = eft_pkg::OP_PKT;
                else
                    cmd_in.op = eft_pkg::OP_QUERY;   // tracking disabled
            end
            eft_pkg::MODE_QUERY:
                cmd_in.op = out_of_range ? eft_pkg::OP_NULL : eft_pkg::OP_QUERY;
            default: cmd_in.op = eft_pkg::OP_NULL;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2) && !status.clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ status.pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, status.pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

endmodule

// File: src/eft_back.sv
// Back end: clears the flow table, runs packet, query and sweep commands.
// Depends on eft_pkg and eft_ram.
module eft_back #(
    parameter int NUM_FLOWS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [eft_pkg::THR_W-1:0]   threshold,
    input  eft_pkg::q_head_t            head,
    output eft_pkg::back_status_t       status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_elephant,
    output logic [eft_pkg::CNT_W-1:0]   flow_bytes,
    output logic [eft_pkg::DEM_W-1:0]   demoted_count
);

    localparam int AW = $clog2(NUM_FLOWS);
    localparam logic [AW-1:0] LAST = AW'(NUM_FLOWS - 1);
    localparam int EW = $bits(eft_pkg::entry_t);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_SWEND = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             sw_addr_reg, sw_addr_next;
    logic [AW-1:0]             wr_addr_reg, wr_addr_next;
    logic                      sw_vld_reg, sw_vld_next;
    logic [eft_pkg::DEM_W-1:0] dem_reg, dem_next;
    logic                      out_valid_reg, out_valid_next;
    eft_pkg::cmd_t             cmd_reg, cmd_next;

    logic                      load;
    logic                      res_el;
    logic [eft_pkg::CNT_W-1:0] res_bytes;
    logic [eft_pkg::DEM_W-1:0] res_dem;
    logic                      is_elephant_reg;
    logic [eft_pkg::CNT_W-1:0] flow_bytes_reg;
    logic [eft_pkg::DEM_W-1:0] demoted_count_reg;

    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [EW-1:0]             ram_wdata, ram_rdata;
    eft_pkg::entry_t           rd_ent, pkt_ent, sw_ent;
    logic                      slot_free;
    logic [eft_pkg::CNT_W-1:0] thr_ext;
    logic                      sw_demote;

    eft_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_FLOWS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_ent    = eft_pkg::entry_t'(ram_rdata);
    assign thr_ext   = {1'b0, threshold};
    assign slot_free = !out_valid_reg || out_ready;

    // packet update
    always_comb
    begin
        pkt_ent    = rd_ent;
        pkt_ent.ag = 1'b0;
        if (rd_ent.cnt < thr_ext)
        begin
            // count < 2^24 here, so the sum cannot wrap
            pkt_ent.cnt = rd_ent.cnt + eft_pkg::CNT_W'(cmd_reg.len);
            if (thr_ext <= pkt_ent.cnt)
                pkt_ent.el = 1'b1;
        end
    end

    // sweep update of one entry
    always_comb
    begin
        sw_ent    = rd_ent;
        sw_demote = rd_ent.el && rd_ent.ag;
        if (sw_demote)
            sw_ent = '0;
        else if (rd_ent.el)
            sw_ent.ag = 1'b1;
    end

    always_comb
    begin
        state_next   = state_reg;
        sw_addr_next = sw_addr_reg;
        wr_addr_next = wr_addr_reg;
        sw_vld_next  = sw_vld_reg;
        dem_next     = dem_reg;
        cmd_next     = cmd_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = sw_addr_reg;
        status.pop   = 1'b0;
        status.clearing = 1'b0;
        load         = 1'b0;
        res_el       = 1'b0;
        res_bytes    = '0;
        res_dem      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                status.clearing = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = sw_addr_reg;
                sw_addr_next = sw_addr_reg + 1'b1;
                if (sw_addr_reg == LAST)
                begin
                    sw_addr_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = AW'(head.cmd.flow);
                if (head.valid && slot_free)
                begin
                    status.pop = 1'b1;
                    cmd_next   = head.cmd;
                    unique case (head.cmd.op) inside
                        eft_pkg::OP_SWEEP:
                        begin
                            sw_addr_next = '0;
                            sw_vld_next  = 1'b0;
                            dem_next     = '0;
                            state_next   = ST_SWEEP;
                        end
                        eft_pkg::OP_PKT, eft_pkg::OP_QUERY:
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_EXEC;
                        end
                        default:
                        begin
                            load = 1'b1;    // null item: all-zero result
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                load       = 1'b1;
                state_next = ST_IDLE;
                ram_waddr  = AW'(cmd_reg.flow);
                if (cmd_reg.op == eft_pkg::OP_PKT)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pkt_ent;
                    res_el    = pkt_ent.el;
                    res_bytes = pkt_ent.cnt;
                end
                else
                begin
                    res_el    = rd_ent.el;
                    res_bytes = rd_ent.cnt;
                end
            end
            ST_SWEEP:
            begin
                // read entry n while writing back entry n-1
                ram_re       = 1'b1;
                ram_raddr    = sw_addr_reg;
                wr_addr_next = sw_addr_reg;
                sw_vld_next  = 1'b1;
                sw_addr_next = sw_addr_reg + 1'b1;
                if (sw_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = sw_ent;
                    if (sw_demote && dem_reg != eft_pkg::DEMOTED_MAX)
                        dem_next = dem_reg + 1'b1;
                end
                if (sw_addr_reg == LAST)
                    state_next = ST_SWEND;
            end
            ST_SWEND:
            begin
                ram_we      = 1'b1;
                ram_wdata   = sw_ent;
                sw_vld_next = 1'b0;
                res_dem     = dem_reg;
                if (sw_demote && dem_reg != eft_pkg::DEMOTED_MAX)
                    res_dem = dem_reg + 1'b1;
                load        = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sw_addr_reg   <= '0;
            sw_vld_reg    <= 1'b0;
            dem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_addr_reg   <= sw_addr_next;
            sw_vld_reg    <= sw_vld_next;
            dem_reg       <= dem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        wr_addr_reg <= wr_addr_next;
        if (load)
        begin
            is_elephant_reg   <= res_el;
            flow_bytes_reg    <= res_bytes;
            demoted_count_reg <= res_dem;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_elephant   = is_elephant_reg;
    assign flow_bytes    = flow_bytes_reg;
    assign demoted_count = demoted_count_reg;

endmodule

// File: src/elephant_flow_tracker.sv
// Elephant flow tracker top level: threshold register, front end, back end.
// Depends on eft_pkg, eft_front, eft_back and the assertion header.
//
// Per-flow byte counts with elephant and aged marks in one table RAM. After
// reset the table is cleared, one entry a cycle, and no item is accepted
// until that pass ends (threshold writes are taken). Items pass through a
// two-entry command queue to the back end, which reads and writes the single
// table RAM: a packet or query does a registered read, then gives its result
// (a packet updates the entry and writes it back), a mode 3 or out-of-range
// item gives an all-zero result, and an aging sweep is issued, then reads each
// entry while writing back the one before, then does the last write back. A
// result waits in an output register while the queue keeps taking items.
`include "elephant_flow_tracker_assert.svh"

module elephant_flow_tracker #(
    parameter int NUM_FLOWS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [eft_pkg::THR_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  mode,
    input  logic [eft_pkg::FLOW_W-1:0]  flow_id,
    input  logic [eft_pkg::LEN_W-1:0]   byte_length,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_elephant,
    output logic [eft_pkg::CNT_W-1:0]   flow_bytes,
    output logic [eft_pkg::DEM_W-1:0]   demoted_count
);

    logic [eft_pkg::THR_W-1:0] thr_reg;
    eft_pkg::q_head_t          head;
    eft_pkg::back_status_t     status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    eft_front #(
        .NUM_FLOWS (NUM_FLOWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .flow_id     (flow_id),
        .byte_length (byte_length),
        .threshold   (thr_reg),
        .status      (status),
        .head        (head)
    );

    eft_back #(
        .NUM_FLOWS (NUM_FLOWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .threshold     (thr_reg),
        .head          (head),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_elephant   (is_elephant),
        .flow_bytes    (flow_bytes),
        .demoted_count (demoted_count)
    );

    `EFT_ASSERT_IMP(a_no_accept_in_clear, status.clearing, !in_ready)
    `EFT_ASSERT_IMP(a_pop_needs_item, status.pop, head.valid)
    `EFT_ASSERT_IMP(a_pop_needs_slot, status.pop, (!out_valid || out_ready))
    `EFT_ASSERT_NXT(a_no_pop_in_clear, status.clearing, !(status.pop && $past(status.clearing)))

endmodule

// File: sim/tb.sv
// Self-checking testbench for elephant_flow_tracker: directed and random items,
// predicted in a local table model and checked field by field at the output.
// Depends on eft_pkg and the tracker RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLOWS      = 1024;
    localparam int CYCLE_CAP  = 800000;
    localparam int HOT_MAX    = 8;

    typedef struct {
        logic                      el;
        logic [eft_pkg::CNT_W-1:0] bytes;
        logic [eft_pkg::DEM_W-1:0] demoted;
    } tracker_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [eft_pkg::THR_W-1:0]  cfg_wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 mode;
    logic [eft_pkg::FLOW_W-1:0] flow_id;
    logic [eft_pkg::LEN_W-1:0]  byte_length;
    logic                       out_valid;
    logic                       out_ready;
    logic                       is_elephant;
    logic [eft_pkg::CNT_W-1:0]  flow_bytes;
    logic [eft_pkg::DEM_W-1:0]  demoted_count;

    // local copy of the flow table and the threshold
    logic [eft_pkg::CNT_W-1:0]  count_tbl [FLOWS];
    bit                         elephant_tbl [FLOWS];
    bit                         aged_tbl [FLOWS];
    logic [eft_pkg::THR_W-1:0]  threshold_model;

    tracker_result_t   pending_results [$];
    tracker_result_t   oldest;
    int                fail_cnt;
    int                cycle_cnt;
    int                idle_streak [2];
    bit                tx_burst;
    int                rx_hold_cycles;
    int                hot_flows [HOT_MAX];

    elephant_flow_tracker #(
        .NUM_FLOWS(FLOWS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .flow_id(flow_id),
        .byte_length(byte_length),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_elephant(is_elephant),
        .flow_bytes(flow_bytes),
        .demoted_count(demoted_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    // side 0 is the sender, side 1 the receiver; occasional runs without idling
    function automatic int draw_wait(input int side);
        if (idle_streak[side] > 0)
        begin
            idle_streak[side]--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            idle_streak[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic tracker_result_t track_flow(input eft_pkg::op_t op,
                                                   input int unsigned flow,
                                                   input int unsigned len);
        tracker_result_t res;
        logic [eft_pkg::DEM_W-1:0] demoted;
        res.el      = 1'b0;
        res.bytes   = '0;
        res.demoted = '0;
        if (op == eft_pkg::OP_SWEEP)
        begin
            demoted = '0;
            for (int i = 0; i < FLOWS; i++)
            begin
                if (elephant_tbl[i])
                begin
                    if (aged_tbl[i])
                    begin
                        aged_tbl[i]     = 1'b0;
                        elephant_tbl[i] = 1'b0;
                        count_tbl[i]    = '0;
                        if (demoted != eft_pkg::DEMOTED_MAX)
                            demoted++;
                    end
                    else
                        aged_tbl[i] = 1'b1;
                end
            end
            res.demoted = demoted;
        end
        else if (op != eft_pkg::OP_NULL && flow < FLOWS)
        begin
            if (op == eft_pkg::OP_PKT && threshold_model != '0)
            begin
                // no add once the count is at or past the threshold
                if (count_tbl[flow] < threshold_model)
                begin
                    count_tbl[flow] = count_tbl[flow]
                                      + eft_pkg::CNT_W'(len[eft_pkg::LEN_W-1:0]);
                    if (threshold_model <= count_tbl[flow])
                        elephant_tbl[flow] = 1'b1;
                end
                aged_tbl[flow] = 1'b0;
            end
            res.el    = elephant_tbl[flow];
            res.bytes = count_tbl[flow];
        end
        return res;
    endfunction

    task automatic send_item(input eft_pkg::op_t op, input int unsigned flow,
                             input int unsigned len);
        int gap;
        gap = tx_burst ? 0 : draw_wait(0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        flow_id     <= flow[eft_pkg::FLOW_W-1:0];
        byte_length <= len[eft_pkg::LEN_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        pending_results = {pending_results, track_flow(op, flow, len)};
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [eft_pkg::THR_W-1:0] value);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        threshold_model = value;
    endtask

    // receiver: per-result stall, plus a long hold-off when one is requested
    initial
    begin
        int n;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                n = draw_wait(1);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_cnt++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (is_elephant !== oldest.el)
                begin
                    $error("is_elephant: expected %0d, got %0d", oldest.el, is_elephant);
                    fail_cnt++;
                end
                if (flow_bytes !== oldest.bytes)
                begin
                    $error("flow_bytes: expected %0d, got %0d", oldest.bytes, flow_bytes);
                    fail_cnt++;
                end
                if (demoted_count !== oldest.demoted)
                begin
                    $error("demoted_count: expected %0d, got %0d",
                           oldest.demoted, demoted_count);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        // threshold still zero from reset: packets change nothing
        send_item(eft_pkg::OP_PKT, 0, 65535);
        send_item(eft_pkg::OP_QUERY, 1023, 0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_NULL, 1023, 65535);
        set_threshold(24'd100);
        send_item(eft_pkg::OP_PKT, 0, 0);
        send_item(eft_pkg::OP_PKT, 0, 60);
        send_item(eft_pkg::OP_PKT, 0, 60);
        send_item(eft_pkg::OP_PKT, 0, 65535);
        send_item(eft_pkg::OP_QUERY, 0, 65535);
        send_item(eft_pkg::OP_SWEEP, 1023, 0);
        // packet on an aged elephant clears the aged mark
        send_item(eft_pkg::OP_PKT, 0, 5);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_QUERY, 0, 0);
        send_item(eft_pkg::OP_PKT, 1023, 65535);
        send_item(eft_pkg::OP_PKT, 2, 70);
        // lowered threshold: count already past it, flow stays a mouse
        set_threshold(24'd50);
        send_item(eft_pkg::OP_PKT, 2, 1);
        send_item(eft_pkg::OP_QUERY, 2, 0);
        // sweeps still age and demote with tracking disabled
        set_threshold(24'd0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_PKT, 1023, 1);
    endtask

    task automatic test_many_elephants();
        set_threshold(24'd1);
        for (int i = 0; i < 120; i++)
            send_item(eft_pkg::OP_PKT, i * 8 + 3,
                      (i % 10 == 0) ? 0 : $urandom_range(1, 65535));
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_QUERY, 3, 0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_QUERY, 11, 0);
    endtask

    task automatic test_max_threshold();
        int unsigned flow;
        flow = $urandom_range(0, FLOWS - 1);
        set_threshold(24'hFFFFFF);
        // 257 full-size packets push the count past 2^24
        for (int i = 0; i < 258; i++)
            send_item(eft_pkg::OP_PKT, flow, 65535);
        send_item(eft_pkg::OP_QUERY, flow, 0);
        send_item(eft_pkg::OP_SWEEP, 0, 0);
        send_item(eft_pkg::OP_QUERY, flow, 0);
    endtask

    task automatic test_random_traffic(input logic [eft_pkg::THR_W-1:0] thr,
                                       input int n_items, input int hot_n);
        int unsigned sel;
        int unsigned flow;
        int unsigned len;
        eft_pkg::op_t op;
        set_threshold(thr);
        for (int i = 0; i < hot_n; i++)
            hot_flows[i] = $urandom_range(0, FLOWS - 1);
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 78)
                op = eft_pkg::OP_PKT;
            else if (sel < 92)
                op = eft_pkg::OP_QUERY;
            else if (sel < 96)
                op = eft_pkg::OP_SWEEP;
            else
                op = eft_pkg::OP_NULL;
            if ($urandom_range(0, 99) < 85)
                flow = hot_flows[$urandom_range(0, hot_n - 1)];
            else
                flow = $urandom_range(0, FLOWS - 1);
            case ($urandom_range(0, 7))
                0: len = 0;
                1: len = 65535;
                2: len = $urandom_range(0, 255);
                default: len = $urandom_range(0, 65535);
            endcase
            send_item(op, flow, len);
        end
    endtask

    task automatic test_backpressure();
        int unsigned flow;
        set_threshold(24'd200000);
        rx_hold_cycles = 400;
        tx_burst = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            flow = (i % 4) * 97;
            send_item((i % 5 == 4) ? eft_pkg::OP_QUERY : eft_pkg::OP_PKT, flow,
                      $urandom_range(0, 65535));
        end
        tx_burst = 1'b0;
        // sender pauses until the block has handed back everything
        wait_results_drained();
        for (int i = 0; i < 20; i++)
            send_item((i % 3 == 2) ? eft_pkg::OP_QUERY : eft_pkg::OP_PKT, (i % 4) * 97,
                      $urandom_range(0, 65535));
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        mode        <= eft_pkg::OP_PKT;
        flow_id     <= '0;
        byte_length <= '0;
        fail_cnt       = 0;
        tx_burst       = 1'b0;
        rx_hold_cycles = 0;
        idle_streak[0] = 0;
        idle_streak[1] = 0;
        threshold_model = '0;
        for (int i = 0; i < FLOWS; i++)
        begin
            count_tbl[i]    = '0;
            elephant_tbl[i] = 1'b0;
            aged_tbl[i]     = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_many_elephants();
        test_max_threshold();
        test_random_traffic(24'($urandom_range(1, 300)), 130, 8);
        test_random_traffic(24'($urandom_range(1000, 200000)), 130, 6);
        test_random_traffic(24'd0, 100, 8);
        test_random_traffic(24'hFFFFFF, 100, 4);
        test_random_traffic(24'($urandom_range(0, 16777215)), 130, 8);
        test_random_traffic(24'd1, 130, 8);
        test_random_traffic(24'($urandom_range(2000, 60000)), 130, 3);
        test_backpressure();

        wait_results_drained();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/eft_pkg.sv
src/eft_ram.sv
src/eft_front.sv
src/eft_back.sv
src/elephant_flow_tracker.sv
sim/tb.sv
